>>> sv/pasa_pkg.sv
`timescale 1ns / 1ps
// pasa_pkg: widths, register indexes and shared types of the allele sharing accumulator
// no dependencies; used by every other file of the block

package pasa_pkg;

	localparam int GENO_W     = 16;
	localparam int SHARED_W   = 22;
	localparam int COUNT_W    = 21;
	localparam int HALVES_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TWO_ALLELE_MODE   = 1'b0,
		REG_COUNT_IBS_CLASSES = 1'b1
	} cfg_reg_t;

	// halves shared at one locus, doubling as the ibs class
	localparam logic [HALVES_W-1:0] HALVES_NONE = 2'd0;
	localparam logic [HALVES_W-1:0] HALVES_ONE  = 2'd1;
	localparam logic [HALVES_W-1:0] HALVES_BOTH = 2'd2;

	typedef struct packed {
		logic two_allele_mode;
		logic count_ibs_classes;
	} cfg_t;

	typedef struct packed {
		logic                missing;
		logic                scored;
		logic [HALVES_W-1:0] halves;
	} locus_eval_t;

endpackage

>>> sv/pasa_cfg_if.sv
`timescale 1ns / 1ps
// pasa_cfg_if: register write channel
// depends on pasa_pkg

interface pasa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pasa_pkg::CFG_IDX_W-1:0]     index;
	logic [pasa_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/pasa_locus_if.sv
`timescale 1ns / 1ps
// pasa_locus_if: one locus of genotype codes for a pair of individuals
// depends on pasa_pkg

interface pasa_locus_if;
	logic                                valid;
	logic                                ready;
	logic signed [pasa_pkg::GENO_W-1:0]  geno_a_first;
	logic signed [pasa_pkg::GENO_W-1:0]  geno_a_second;
	logic signed [pasa_pkg::GENO_W-1:0]  geno_b_first;
	logic signed [pasa_pkg::GENO_W-1:0]  geno_b_second;
	logic                                self_pair;
	logic                                last_locus;

	modport source (output valid, output geno_a_first, output geno_a_second,
		output geno_b_first, output geno_b_second, output self_pair,
		output last_locus, input ready);
	modport sink   (input valid, input geno_a_first, input geno_a_second,
		input geno_b_first, input geno_b_second, input self_pair,
		input last_locus, output ready);
endinterface

>>> sv/pasa_result_if.sv
`timescale 1ns / 1ps
// pasa_result_if: totals of one run of loci
// depends on pasa_pkg

interface pasa_result_if;
	logic                              valid;
	logic                              ready;
	logic [pasa_pkg::SHARED_W-1:0]     shared_halves;
	logic [pasa_pkg::COUNT_W-1:0]      missing_count;
	logic [pasa_pkg::COUNT_W-1:0]      ibs_zero_count;
	logic [pasa_pkg::COUNT_W-1:0]      ibs_one_count;
	logic [pasa_pkg::COUNT_W-1:0]      ibs_two_count;

	modport source (output valid, output shared_halves, output missing_count,
		output ibs_zero_count, output ibs_one_count, output ibs_two_count,
		input ready);
	modport sink   (input valid, input shared_halves, input missing_count,
		input ibs_zero_count, input ibs_one_count, input ibs_two_count,
		output ready);
endinterface

>>> sv/pairwise_allele_sharing_accumulator_top.sv
`timescale 1ns / 1ps
// pairwise_allele_sharing_accumulator_top: allele sharing totals for one pair over a run of loci
// depends on pasa_pkg, the three channel interfaces, pasa_cfg_regs and pasa_accum
//
//  channel  dir  payload                                               transaction
//  cfg      in   index, data                                           register write
//  locus    in   geno_a/b_first/second, self_pair, last_locus          one locus
//  result   out  shared_halves, missing_count, ibs_zero/one/two_count  totals of a run
//
// one locus per cycle, except while a last locus waits on an unclaimed result; a locus is
// scored the cycle after it is taken, in the single input register stage that feeds the saturating counters
// the totals of a run are registered into the result register as its last locus leaves the input stage
// a stalled result holds back only a following last locus; others keep flowing
// arst_n clears modes, counters and valid flags at once; config writes are registered in the mode registers

module pairwise_allele_sharing_accumulator_top (
	input  logic          clk,
	input  logic          arst_n,
	pasa_cfg_if.sink      cfg,
	pasa_locus_if.sink    locus,
	pasa_result_if.source result
);
	pasa_pkg::cfg_t mode;

	pasa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.mode   (mode)
	);

	pasa_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode),
		.locus  (locus),
		.result (result)
	);
endmodule

>>> sv/pasa_cfg_regs.sv
`timescale 1ns / 1ps
// pasa_cfg_regs: mode registers written through the configuration channel
// depends on pasa_pkg and pasa_cfg_if

module pasa_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	pasa_cfg_if.sink        cfg,
	output pasa_pkg::cfg_t  mode
);
	logic two_allele_mode_q;
	logic count_ibs_classes_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_allele_mode_q   <= 1'b0;
			count_ibs_classes_q <= 1'b0;
		end else if (cfg.valid) begin
			case (pasa_pkg::cfg_reg_t'(cfg.index))
				pasa_pkg::REG_TWO_ALLELE_MODE:   two_allele_mode_q   <= cfg.data[0];
				pasa_pkg::REG_COUNT_IBS_CLASSES: count_ibs_classes_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign mode.two_allele_mode   = two_allele_mode_q;
	assign mode.count_ibs_classes = count_ibs_classes_q;
endmodule

>>> sv/pasa_locus_cmp.sv
`timescale 1ns / 1ps
// pasa_locus_cmp: missing check and sharing in halves for one locus
// depends on pasa_pkg

module pasa_locus_cmp (
	input  logic signed [pasa_pkg::GENO_W-1:0] a_first,
	input  logic signed [pasa_pkg::GENO_W-1:0] a_second,
	input  logic signed [pasa_pkg::GENO_W-1:0] b_first,
	input  logic signed [pasa_pkg::GENO_W-1:0] b_second,
	input  logic                               self_pair,
	input  logic                               two_allele_mode,
	output pasa_pkg::locus_eval_t              eval
);
	logic                              a_miss;
	logic                              b_miss;
	logic signed [pasa_pkg::GENO_W:0]  dose_diff;
	logic [pasa_pkg::HALVES_W-1:0]     halves_dose;
	logic [pasa_pkg::HALVES_W-1:0]     halves_pair;

	// sign bits mark missing codes
	assign a_miss = a_first[pasa_pkg::GENO_W-1]
		| (two_allele_mode & a_second[pasa_pkg::GENO_W-1]);
	assign b_miss = b_first[pasa_pkg::GENO_W-1]
		| (two_allele_mode & b_second[pasa_pkg::GENO_W-1]);

	assign dose_diff = {a_first[pasa_pkg::GENO_W-1], a_first}
		- {b_first[pasa_pkg::GENO_W-1], b_first};

	always_comb begin
		if (dose_diff == '0)
			halves_dose = pasa_pkg::HALVES_BOTH;
		else if (dose_diff == (pasa_pkg::GENO_W+1)'(1) || dose_diff == '1)
			halves_dose = pasa_pkg::HALVES_ONE;
		else
			halves_dose = pasa_pkg::HALVES_NONE;
	end

	// alleles matched in either order
	always_comb begin
		if (a_first == b_first)
			halves_pair = (a_second == b_second) ? pasa_pkg::HALVES_BOTH : pasa_pkg::HALVES_ONE;
		else if (a_first == b_second)
			halves_pair = (a_second == b_first) ? pasa_pkg::HALVES_BOTH : pasa_pkg::HALVES_ONE;
		else if (a_second == b_second || a_second == b_first)
			halves_pair = pasa_pkg::HALVES_ONE;
		else
			halves_pair = pasa_pkg::HALVES_NONE;
	end

	assign eval.missing = a_miss | (~self_pair & b_miss);
	assign eval.scored  = ~eval.missing & ~self_pair;
	assign eval.halves  = two_allele_mode ? halves_pair : halves_dose;
endmodule

>>> sv/pasa_accum.sv
`timescale 1ns / 1ps
// pasa_accum: locus input register, saturating run totals and result register
// depends on pasa_pkg, pasa_locus_if, pasa_result_if and pasa_locus_cmp

module pasa_accum (
	input  logic            clk,
	input  logic            arst_n,
	input  pasa_pkg::cfg_t  mode,
	pasa_locus_if.sink      locus,
	pasa_result_if.source   result
);
	localparam int SW = pasa_pkg::SHARED_W;
	localparam int CW = pasa_pkg::COUNT_W;

	logic                               valid_s1;
	logic signed [pasa_pkg::GENO_W-1:0] a_first_s1;
	logic signed [pasa_pkg::GENO_W-1:0] a_second_s1;
	logic signed [pasa_pkg::GENO_W-1:0] b_first_s1;
	logic signed [pasa_pkg::GENO_W-1:0] b_second_s1;
	logic                               self_s1;
	logic                               last_s1;

	logic [SW-1:0] shared_q;
	logic [CW-1:0] missing_q;
	logic [CW-1:0] ibs_zero_q;
	logic [CW-1:0] ibs_one_q;
	logic [CW-1:0] ibs_two_q;

	logic          res_valid_q;
	logic [SW-1:0] res_shared_q;
	logic [CW-1:0] res_missing_q;
	logic [CW-1:0] res_zero_q;
	logic [CW-1:0] res_one_q;
	logic [CW-1:0] res_two_q;

	pasa_pkg::locus_eval_t eval;
	logic                  advance;
	logic                  ibs_on;
	logic [SW:0]           shared_sum;
	logic [SW-1:0]         shared_nx;
	logic [CW-1:0]         missing_nx;
	logic [CW-1:0]         zero_nx;
	logic [CW-1:0]         one_nx;
	logic [CW-1:0]         two_nx;

	pasa_locus_cmp u_cmp (
		.a_first         (a_first_s1),
		.a_second        (a_second_s1),
		.b_first         (b_first_s1),
		.b_second        (b_second_s1),
		.self_pair       (self_s1),
		.two_allele_mode (mode.two_allele_mode),
		.eval            (eval)
	);

	// a last locus waits only while the previous result is still unclaimed
	assign advance     = valid_s1 & (~last_s1 | ~res_valid_q | result.ready);
	assign locus.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (locus.ready)
			valid_s1 <= locus.valid;
	end

	always_ff @(posedge clk) begin
		if (locus.ready && locus.valid) begin
			a_first_s1  <= locus.geno_a_first;
			a_second_s1 <= locus.geno_a_second;
			b_first_s1  <= locus.geno_b_first;
			b_second_s1 <= locus.geno_b_second;
			self_s1     <= locus.self_pair;
			last_s1     <= locus.last_locus;
		end
	end

	// saturating updates
	assign ibs_on     = eval.scored & mode.count_ibs_classes;
	assign shared_sum = {1'b0, shared_q}
		+ (SW+1)'(eval.scored ? eval.halves : pasa_pkg::HALVES_NONE);
	assign shared_nx  = shared_sum[SW] ? '1 : shared_sum[SW-1:0];
	assign missing_nx = (eval.missing && missing_q != '1) ? missing_q + CW'(1) : missing_q;
	assign zero_nx    = (ibs_on && eval.halves == pasa_pkg::HALVES_NONE && ibs_zero_q != '1)
		? ibs_zero_q + CW'(1) : ibs_zero_q;
	assign one_nx     = (ibs_on && eval.halves == pasa_pkg::HALVES_ONE && ibs_one_q != '1)
		? ibs_one_q + CW'(1) : ibs_one_q;
	assign two_nx     = (ibs_on && eval.halves == pasa_pkg::HALVES_BOTH && ibs_two_q != '1)
		? ibs_two_q + CW'(1) : ibs_two_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q   <= '0;
			missing_q  <= '0;
			ibs_zero_q <= '0;
			ibs_one_q  <= '0;
			ibs_two_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				shared_q   <= '0;
				missing_q  <= '0;
				ibs_zero_q <= '0;
				ibs_one_q  <= '0;
				ibs_two_q  <= '0;
			end else begin
				shared_q   <= shared_nx;
				missing_q  <= missing_nx;
				ibs_zero_q <= zero_nx;
				ibs_one_q  <= one_nx;
				ibs_two_q  <= two_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance && last_s1)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_shared_q  <= shared_nx;
			res_missing_q <= missing_nx;
			res_zero_q    <= zero_nx;
			res_one_q     <= one_nx;
			res_two_q     <= two_nx;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.shared_halves  = res_shared_q;
	assign result.missing_count  = res_missing_q;
	assign result.ibs_zero_count = res_zero_q;
	assign result.ibs_one_count  = res_one_q;
	assign result.ibs_two_count  = res_two_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> shared_q == '0 && missing_q == '0 && ibs_zero_q == '0
			&& ibs_one_q == '0 && ibs_two_q == '0)
		else $error("run totals not cleared after last locus");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance && last_s1))
		else $error("result raised without a last locus");

	a_last_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && res_valid_q && !result.ready |=> valid_s1 && last_s1)
		else $error("last locus dropped while result stalled");

	a_ibs_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && !mode.count_ibs_classes |=>
			$stable(ibs_zero_q) && $stable(ibs_one_q) && $stable(ibs_two_q))
		else $error("ibs counts moved while counting disabled");

	a_one_class_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |-> $countones({zero_nx != ibs_zero_q, one_nx != ibs_one_q,
			two_nx != ibs_two_q, missing_nx != missing_q}) <= 1)
		else $error("more than one locus class counted");
endmodule
